/* rtl/sotf_pkg.sv */
package sotf_pkg;

	localparam int WORD_W = 64;
	localparam int HALF_W = 32;
	localparam int PROD_W = 2 * WORD_W;
	localparam int WIDE_W = 62;
	localparam logic signed [WORD_W-1:0] WIDE_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;

	localparam int CFG_IDX_W = 3;
	localparam int STEP_W = 6;
	localparam int NUM_STEPS = 34;
	localparam int MUL_W = 3;
	localparam logic [MUL_W-1:0] MUL_LAST = 3'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_S2 = 3'd0,
		CFG_NUM_S1 = 3'd1,
		CFG_NUM_S0 = 3'd2,
		CFG_DEN_S2 = 3'd3,
		CFG_DEN_S1 = 3'd4,
		CFG_DEN_S0 = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_MUL,
		ST_DIV,
		ST_WB,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_SC2,
		OP_SC4,
		OP_SC8,
		OP_MUL,
		OP_CHK,
		OP_DIV
	} op_t;

	typedef enum logic [4:0] {
		R_T, R_U, R_NS2, R_NS1, R_NS0, R_DS2, R_DS1, R_DS0,
		R_PI1, R_PI2, R_PO1, R_PO2,
		R_T2, R_N1T, R_D1T, R_N2X4, R_D2X4, R_N0T2, R_D0T2,
		R_DEN, R_CA, R_CB, R_CC, R_CD, R_CE, R_ACC, R_TMP
	} reg_sel_t;

	typedef struct packed {
		op_t      op;
		reg_sel_t src_a;
		reg_sel_t src_b;
		reg_sel_t dst;
	} uop_t;

	// coefficient build, zero check, accumulation, final divide
	function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
		uop_t u;
		case (step)
			6'd0:  u = '{OP_MUL, R_T,    R_T,    R_T2};
			6'd1:  u = '{OP_MUL, R_NS1,  R_T,    R_N1T};
			6'd2:  u = '{OP_MUL, R_DS1,  R_T,    R_D1T};
			6'd3:  u = '{OP_SC4, R_NS2,  R_NS2,  R_N2X4};
			6'd4:  u = '{OP_SC4, R_DS2,  R_DS2,  R_D2X4};
			6'd5:  u = '{OP_SC2, R_N1T,  R_N1T,  R_N1T};
			6'd6:  u = '{OP_SC2, R_D1T,  R_D1T,  R_D1T};
			6'd7:  u = '{OP_MUL, R_NS0,  R_T2,   R_N0T2};
			6'd8:  u = '{OP_MUL, R_DS0,  R_T2,   R_D0T2};
			6'd9:  u = '{OP_ADD, R_D2X4, R_D1T,  R_DEN};
			6'd10: u = '{OP_ADD, R_DEN,  R_D0T2, R_DEN};
			6'd11: u = '{OP_CHK, R_DEN,  R_DEN,  R_DEN};
			6'd12: u = '{OP_ADD, R_N2X4, R_N1T,  R_CA};
			6'd13: u = '{OP_ADD, R_CA,   R_N0T2, R_CA};
			6'd14: u = '{OP_SC2, R_N0T2, R_N0T2, R_CB};
			6'd15: u = '{OP_SC8, R_NS2,  R_NS2,  R_TMP};
			6'd16: u = '{OP_SUB, R_CB,   R_TMP,  R_CB};
			6'd17: u = '{OP_SUB, R_N2X4, R_N1T,  R_CC};
			6'd18: u = '{OP_ADD, R_CC,   R_N0T2, R_CC};
			6'd19: u = '{OP_SC2, R_D0T2, R_D0T2, R_CD};
			6'd20: u = '{OP_SC8, R_DS2,  R_DS2,  R_TMP};
			6'd21: u = '{OP_SUB, R_CD,   R_TMP,  R_CD};
			6'd22: u = '{OP_SUB, R_D2X4, R_D1T,  R_CE};
			6'd23: u = '{OP_ADD, R_CE,   R_D0T2, R_CE};
			6'd24: u = '{OP_MUL, R_U,    R_CA,   R_ACC};
			6'd25: u = '{OP_MUL, R_PI1,  R_CB,   R_TMP};
			6'd26: u = '{OP_ADD, R_ACC,  R_TMP,  R_ACC};
			6'd27: u = '{OP_MUL, R_PI2,  R_CC,   R_TMP};
			6'd28: u = '{OP_ADD, R_ACC,  R_TMP,  R_ACC};
			6'd29: u = '{OP_MUL, R_PO1,  R_CD,   R_TMP};
			6'd30: u = '{OP_SUB, R_ACC,  R_TMP,  R_ACC};
			6'd31: u = '{OP_MUL, R_PO2,  R_CE,   R_TMP};
			6'd32: u = '{OP_SUB, R_ACC,  R_TMP,  R_ACC};
			default: u = '{OP_DIV, R_ACC, R_DEN, R_ACC};
		endcase
		return u;
	endfunction

	function automatic logic [WORD_W-1:0] mag(input logic signed [WORD_W-1:0] a);
		logic [WORD_W-1:0] m;
		m = a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
		return m;
	endfunction

	function automatic logic signed [WORD_W-1:0] clamp_wide(
		input logic signed [WORD_W-1:0] a
	);
		logic signed [WORD_W-1:0] r;
		if (a > WIDE_MAX) r = WIDE_MAX;
		else if (a < -WIDE_MAX) r = -WIDE_MAX;
		else r = a;
		return r;
	endfunction

	function automatic logic signed [WORD_W-1:0] sat_add(
		input logic signed [WORD_W-1:0] a,
		input logic signed [WORD_W-1:0] b
	);
		logic signed [WORD_W:0] s;
		logic signed [WORD_W:0] lim;
		logic signed [WORD_W-1:0] r;
		lim = (WORD_W+1)'(WIDE_MAX);
		s = (WORD_W+1)'(clamp_wide(a)) + (WORD_W+1)'(clamp_wide(b));
		if (s > lim) r = WIDE_MAX;
		else if (s < -lim) r = -WIDE_MAX;
		else r = WORD_W'(s);
		return r;
	endfunction

	// a times 2^sh, saturated
	function automatic logic signed [WORD_W-1:0] scale(
		input logic signed [WORD_W-1:0] a,
		input logic [1:0] sh
	);
		logic [WORD_W+2:0] m;
		logic signed [WORD_W-1:0] r;
		m = (WORD_W+3)'(mag(a)) << sh;
		if (m > (WORD_W+3)'(WIDE_MAX)) r = WIDE_MAX;
		else r = WORD_W'(m);
		return a[WORD_W-1] ? -r : r;
	endfunction

endpackage

/* rtl/second_order_tustin_filter_top.sv */
// Second-order filter (num_s2 s^2 + num_s1 s + num_s0) / (den_s2 s^2 + den_s1 s + den_s0),
// discretized by the bilinear rule per item from the item's step time, in signed
// fixed point with FRAC_BITS fraction bits. Each item gives exactly one result. A step
// time of zero holds all state and returns the last output; a discrete denominator of
// zero does the same and sets zero_denominator. One item is worked at a time: a computed
// item passes through 34 sequencer steps, ten products on one shared 32x32 multiplier,
// and a restoring divider that retires one quotient bit per cycle; a held item goes
// straight from acceptance to the output stage. A new item is taken as soon as the
// sequencer is idle, even while the previous result waits in the output register.
// Coefficients are written through the cfg port; the user must write them only while
// idle, which the block itself does not enforce. Indexes above five are ignored.
module second_order_tustin_filter_top #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,

	input  logic s_tvalid,
	output logic s_tready,
	// step_time [DATA_WIDTH-2:0], sample_in, zero pad
	input  logic [((2*DATA_WIDTH+6)/8)*8-1:0] s_tdata,

	output logic m_tvalid,
	input  logic m_tready,
	// sample_out, zero pad
	output logic [((DATA_WIDTH+7)/8)*8-1:0] m_tdata,
	// zero_denominator
	output logic m_tuser,

	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [sotf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_WIDTH-1:0] cfg_data
);
	import sotf_pkg::*;

	localparam int NUM_W = WIDE_W + FRAC_BITS;
	localparam int DCNT_W = $clog2(NUM_W + 1);
	localparam logic signed [WORD_W-1:0] DATA_MAX =
		signed'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
	localparam logic signed [WORD_W-1:0] DATA_MIN = ~DATA_MAX;

	state_t state_q, state_d;

	logic signed [DATA_WIDTH-1:0] num_s2_q, num_s1_q, num_s0_q;
	logic signed [DATA_WIDTH-1:0] den_s2_q, den_s1_q, den_s0_q;
	logic signed [DATA_WIDTH-1:0] prev_in_1_q, prev_in_2_q, prev_out_1_q, prev_out_2_q;
	logic signed [DATA_WIDTH-1:0] last_output_q;

	logic [DATA_WIDTH-2:0] t_q;
	logic signed [DATA_WIDTH-1:0] u_q;
	logic signed [WORD_W-1:0] t2_q, n1t_q, d1t_q, n2x4_q, d2x4_q, n0t2_q, d0t2_q;
	logic signed [WORD_W-1:0] den_q, ca_q, cb_q, cc_q, cd_q, ce_q, acc_q, tmp_q;

	logic [STEP_W-1:0] step_q;
	logic [MUL_W-1:0] mcnt_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic flag_q;

	logic [WORD_W-1:0] opa_q, opb_q;
	logic neg_q;
	logic [WORD_W-1:0] pp_s1;
	logic [PROD_W-1:0] prod_q;
	logic [WIDE_W-1:0] rem_q, dvs_q;
	logic [NUM_W-1:0] quo_q;

	logic m_tvalid_q;
	logic [DATA_WIDTH-1:0] m_data_q;
	logic m_flag_q;

	logic accept, alu_wr, mul_wr, step_inc, mul_start, div_start, chk_zero, wb, out_load;

	uop_t uop;
	logic signed [WORD_W-1:0] a_val, b_val, alu_res, mul_res, wr_val;
	logic [WORD_W-1:0] a_mag, b_mag;
	logic [PROD_W-1:0] prod_sh, pp_ext;
	logic [WORD_W-1:0] mul_mag;
	logic [HALF_W-1:0] a_half, b_half;
	logic [MUL_W-1:0] kp;
	logic [WIDE_W:0] trial;
	logic trial_ge;
	logic signed [WORD_W-1:0] q_val, y_wide;
	logic signed [DATA_WIDTH-1:0] y_val;

	function automatic logic signed [WORD_W-1:0] read_reg(input reg_sel_t sel);
		logic signed [WORD_W-1:0] v;
		case (sel)
			R_T:    v = WORD_W'(t_q);
			R_U:    v = WORD_W'(u_q);
			R_NS2:  v = WORD_W'(num_s2_q);
			R_NS1:  v = WORD_W'(num_s1_q);
			R_NS0:  v = WORD_W'(num_s0_q);
			R_DS2:  v = WORD_W'(den_s2_q);
			R_DS1:  v = WORD_W'(den_s1_q);
			R_DS0:  v = WORD_W'(den_s0_q);
			R_PI1:  v = WORD_W'(prev_in_1_q);
			R_PI2:  v = WORD_W'(prev_in_2_q);
			R_PO1:  v = WORD_W'(prev_out_1_q);
			R_PO2:  v = WORD_W'(prev_out_2_q);
			R_T2:   v = t2_q;
			R_N1T:  v = n1t_q;
			R_D1T:  v = d1t_q;
			R_N2X4: v = n2x4_q;
			R_D2X4: v = d2x4_q;
			R_N0T2: v = n0t2_q;
			R_D0T2: v = d0t2_q;
			R_DEN:  v = den_q;
			R_CA:   v = ca_q;
			R_CB:   v = cb_q;
			R_CC:   v = cc_q;
			R_CD:   v = cd_q;
			R_CE:   v = ce_q;
			R_ACC:  v = acc_q;
			R_TMP:  v = tmp_q;
			default: v = '0;
		endcase
		return v;
	endfunction

	assign uop = uop_at(step_q);

	always_comb begin
		a_val = read_reg(uop.src_a);
		b_val = read_reg(uop.src_b);
		a_mag = mag(a_val);
		b_mag = mag(b_val);
		case (uop.op)
			OP_ADD:  alu_res = sat_add(a_val, b_val);
			OP_SUB:  alu_res = sat_add(a_val, -clamp_wide(b_val));
			OP_SC2:  alu_res = scale(a_val, 2'd1);
			OP_SC4:  alu_res = scale(a_val, 2'd2);
			OP_SC8:  alu_res = scale(a_val, 2'd3);
			default: alu_res = a_val;
		endcase
	end

	// shared multiplier: four 32x32 partial products, then shift and saturate
	always_comb begin
		a_half = mcnt_q[0] ? opa_q[WORD_W-1:HALF_W] : opa_q[HALF_W-1:0];
		b_half = mcnt_q[1] ? opb_q[WORD_W-1:HALF_W] : opb_q[HALF_W-1:0];
		kp = mcnt_q - MUL_W'(1);
		case (kp[1:0])
			2'b00:   pp_ext = PROD_W'(pp_s1);
			2'b11:   pp_ext = PROD_W'(pp_s1) << (2 * HALF_W);
			default: pp_ext = PROD_W'(pp_s1) << HALF_W;
		endcase
		prod_sh = prod_q >> FRAC_BITS;
		if (|prod_sh[PROD_W-1:WIDE_W]) mul_mag = WIDE_MAX;
		else mul_mag = WORD_W'(prod_sh[WIDE_W-1:0]);
		mul_res = neg_q ? -signed'(mul_mag) : signed'(mul_mag);
	end

	assign wr_val = mul_wr ? mul_res : alu_res;

	// restoring divider, one quotient bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		trial_ge = trial >= {1'b0, dvs_q};
		if (dvs_q == '0) q_val = '0;
		else if (|quo_q[NUM_W-1:WIDE_W]) q_val = WIDE_MAX;
		else q_val = WORD_W'(quo_q[WIDE_W-1:0]);
		y_wide = neg_q ? -q_val : q_val;
		if (y_wide > DATA_MAX) y_val = DATA_WIDTH'(DATA_MAX);
		else if (y_wide < DATA_MIN) y_val = DATA_WIDTH'(DATA_MIN);
		else y_val = DATA_WIDTH'(y_wide);
	end

	always_comb begin
		state_d = state_q;
		accept = 1'b0;
		alu_wr = 1'b0;
		mul_wr = 1'b0;
		step_inc = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		chk_zero = 1'b0;
		wb = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: if (s_tvalid) begin
				accept = 1'b1;
				state_d = (s_tdata[DATA_WIDTH-2:0] == '0) ? ST_DONE : ST_ISSUE;
			end
			ST_ISSUE: begin
				case (uop.op)
					OP_MUL: begin
						mul_start = 1'b1;
						state_d = ST_MUL;
					end
					OP_DIV: begin
						div_start = 1'b1;
						state_d = ST_DIV;
					end
					OP_CHK: begin
						if (den_q == '0) begin
							chk_zero = 1'b1;
							state_d = ST_DONE;
						end else begin
							step_inc = 1'b1;
						end
					end
					default: begin
						alu_wr = 1'b1;
						step_inc = 1'b1;
					end
				endcase
			end
			ST_MUL: if (mcnt_q == MUL_LAST) begin
				mul_wr = 1'b1;
				step_inc = 1'b1;
				state_d = ST_ISSUE;
			end
			ST_DIV: if (dcnt_q == DCNT_W'(NUM_W - 1)) begin
				state_d = ST_WB;
			end
			ST_WB: begin
				wb = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: if (!m_tvalid_q || m_tready) begin
				out_load = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_s2_q <= '0;
			num_s1_q <= '0;
			num_s0_q <= '0;
			den_s2_q <= '0;
			den_s1_q <= '0;
			den_s0_q <= '0;
			prev_in_1_q <= '0;
			prev_in_2_q <= '0;
			prev_out_1_q <= '0;
			prev_out_2_q <= '0;
			last_output_q <= '0;
			step_q <= '0;
			mcnt_q <= '0;
			dcnt_q <= '0;
			flag_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_NUM_S2: num_s2_q <= cfg_data;
					CFG_NUM_S1: num_s1_q <= cfg_data;
					CFG_NUM_S0: num_s0_q <= cfg_data;
					CFG_DEN_S2: den_s2_q <= cfg_data;
					CFG_DEN_S1: den_s1_q <= cfg_data;
					CFG_DEN_S0: den_s0_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				step_q <= '0;
				flag_q <= 1'b0;
			end else if (step_inc) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (chk_zero) flag_q <= 1'b1;
			if (state_q == ST_MUL) begin
				mcnt_q <= (mcnt_q == MUL_LAST) ? '0 : mcnt_q + MUL_W'(1);
			end
			if (div_start) dcnt_q <= '0;
			else if (state_q == ST_DIV) begin
				dcnt_q <= (dcnt_q == DCNT_W'(NUM_W - 1)) ? '0 : dcnt_q + DCNT_W'(1);
			end
			if (wb) begin
				prev_in_2_q <= prev_in_1_q;
				prev_in_1_q <= u_q;
				prev_out_2_q <= prev_out_1_q;
				prev_out_1_q <= y_val;
				last_output_q <= y_val;
			end
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			t_q <= s_tdata[DATA_WIDTH-2:0];
			u_q <= s_tdata[2*DATA_WIDTH-2:DATA_WIDTH-1];
		end
		if (alu_wr || mul_wr) begin
			case (uop.dst)
				R_T2:   t2_q <= wr_val;
				R_N1T:  n1t_q <= wr_val;
				R_D1T:  d1t_q <= wr_val;
				R_N2X4: n2x4_q <= wr_val;
				R_D2X4: d2x4_q <= wr_val;
				R_N0T2: n0t2_q <= wr_val;
				R_D0T2: d0t2_q <= wr_val;
				R_DEN:  den_q <= wr_val;
				R_CA:   ca_q <= wr_val;
				R_CB:   cb_q <= wr_val;
				R_CC:   cc_q <= wr_val;
				R_CD:   cd_q <= wr_val;
				R_CE:   ce_q <= wr_val;
				R_ACC:  acc_q <= wr_val;
				R_TMP:  tmp_q <= wr_val;
				default: ;
			endcase
		end
		if (mul_start) begin
			opa_q <= a_mag;
			opb_q <= b_mag;
			neg_q <= a_val[WORD_W-1] ^ b_val[WORD_W-1];
			prod_q <= '0;
		end
		if (state_q == ST_MUL) begin
			if (!mcnt_q[MUL_W-1]) pp_s1 <= WORD_W'(a_half) * WORD_W'(b_half);
			if (mcnt_q != '0 && mcnt_q != MUL_LAST) prod_q <= prod_q + pp_ext;
		end
		if (div_start) begin
			neg_q <= a_val[WORD_W-1] ^ b_val[WORD_W-1];
			quo_q <= {a_mag[WIDE_W-1:0], {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			dvs_q <= b_mag[WIDE_W-1:0];
		end else if (state_q == ST_DIV) begin
			rem_q <= trial_ge ? WIDE_W'(trial - {1'b0, dvs_q}) : WIDE_W'(trial);
			quo_q <= {quo_q[NUM_W-2:0], trial_ge};
		end
		if (out_load) begin
			m_data_q <= last_output_q;
			m_flag_q <= flag_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tuser = m_flag_q;

	always_comb begin
		m_tdata = '0;
		m_tdata[DATA_WIDTH-1:0] = m_data_q;
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q < STEP_W'(NUM_STEPS))
		else $error("sequencer step out of range");

	a_mcnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_MUL |-> mcnt_q == '0)
		else $error("multiplier counter busy outside multiply");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && dvs_q != '0) |-> rem_q < dvs_q)
		else $error("divider remainder not below divisor");

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_ISSUE || state_q == ST_DONE))
		else $error("accepted item not started");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result offered without finishing an item");

endmodule

/* test/tustin_filter_checker.sv */
`timescale 1ns / 1ps

module tustin_filter_checker
	import sotf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          outstanding
);

	localparam int     FRAC = 16;
	localparam longint SAT_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam longint Q_ONE = 64'sd65536;
	localparam longint OUT_HI = 64'sd2147483647;
	localparam longint OUT_LO = -64'sd2147483648;

	typedef struct packed {
		logic [31:0] sample_out;
		logic        zero_denominator;
	} filter_out_t;

	filter_out_t expected_q[$];
	int errors;

	longint k_n2, k_n1, k_n0, k_d2, k_d1, k_d0;
	longint in_1, in_2, out_1, out_2, last_y;

	function automatic longint clip62(input longint a);
		if (a > SAT_LIM) return SAT_LIM;
		if (a < -SAT_LIM) return -SAT_LIM;
		return a;
	endfunction

	function automatic longint add_sat(input longint a, input longint b);
		return clip62(clip62(a) + clip62(b));
	endfunction

	function automatic longint sub_sat(input longint a, input longint b);
		longint nb;
		nb = (b < -SAT_LIM) ? -SAT_LIM : b;
		return add_sat(a, -nb);
	endfunction

	function automatic longint fx_mul(input longint a, input longint b);
		logic [63:0]  ua, ub;
		logic [127:0] p;
		longint r;
		ua = (a < 0) ? 64'(-a) : 64'(a);
		ub = (b < 0) ? 64'(-b) : 64'(b);
		p = ({64'd0, ua} * {64'd0, ub}) >> FRAC;
		r = (p > 128'(SAT_LIM)) ? SAT_LIM : longint'(p[63:0]);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic longint fx_div(input longint a, input longint b);
		logic [63:0]  ua, ub;
		logic [127:0] q;
		longint r;
		ua = (a < 0) ? 64'(-a) : 64'(a);
		ub = (b < 0) ? 64'(-b) : 64'(b);
		if (ub == 64'd0 || ub > 64'(SAT_LIM))
			return 0;
		q = ({64'd0, ua} << FRAC) / {64'd0, ub};
		r = (q > 128'(SAT_LIM)) ? SAT_LIM : longint'(q[63:0]);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic longint clip_out(input longint v);
		if (v > OUT_HI) return OUT_HI;
		if (v < OUT_LO) return OUT_LO;
		return v;
	endfunction

	task automatic filter_step(input logic [30:0] dt, input logic [31:0] x,
			output filter_out_t r);
		longint t, u, t2, n1t, d1t, n2x4, d2x4, n1t2, d1t2, n0t2, d0t2;
		longint ca, cb, cc, cd, ce, den, acc, y;
		logic held_zero;
		t = longint'(dt);
		u = longint'(signed'(x));
		held_zero = 1'b0;
		if (t != 0) begin
			t2 = fx_mul(t, t);
			n1t = fx_mul(k_n1, t);
			d1t = fx_mul(k_d1, t);
			n2x4 = fx_mul(k_n2, 4 * Q_ONE);
			d2x4 = fx_mul(k_d2, 4 * Q_ONE);
			n1t2 = fx_mul(n1t, 2 * Q_ONE);
			d1t2 = fx_mul(d1t, 2 * Q_ONE);
			n0t2 = fx_mul(k_n0, t2);
			d0t2 = fx_mul(k_d0, t2);
			den = add_sat(add_sat(d2x4, d1t2), d0t2);
			if (den == 0) begin
				held_zero = 1'b1;
			end else begin
				ca = add_sat(add_sat(n2x4, n1t2), n0t2);
				cb = sub_sat(fx_mul(n0t2, 2 * Q_ONE), fx_mul(k_n2, 8 * Q_ONE));
				cc = add_sat(sub_sat(n2x4, n1t2), n0t2);
				cd = sub_sat(fx_mul(d0t2, 2 * Q_ONE), fx_mul(k_d2, 8 * Q_ONE));
				ce = add_sat(sub_sat(d2x4, d1t2), d0t2);
				acc = fx_mul(u, ca);
				acc = add_sat(acc, fx_mul(in_1, cb));
				acc = add_sat(acc, fx_mul(in_2, cc));
				acc = sub_sat(acc, fx_mul(out_1, cd));
				acc = sub_sat(acc, fx_mul(out_2, ce));
				y = clip_out(fx_div(acc, den));
				in_2 = in_1;
				in_1 = u;
				out_2 = out_1;
				out_1 = y;
				last_y = y;
			end
		end
		r.sample_out = last_y[31:0];
		r.zero_denominator = held_zero;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		if (errors <= 200)
			$display("mismatch: %s got %h want %h at %0t", what, got, want, $realtime);
	endtask

	always @(posedge clk or negedge arst_n) begin
		filter_out_t want;
		if (!arst_n) begin
			k_n2 = 0; k_n1 = 0; k_n0 = 0;
			k_d2 = 0; k_d1 = 0; k_d0 = 0;
			in_1 = 0; in_2 = 0; out_1 = 0; out_2 = 0; last_y = 0;
			expected_q.delete();
			errors = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_NUM_S2: k_n2 = longint'(signed'(cfg_data));
					CFG_NUM_S1: k_n1 = longint'(signed'(cfg_data));
					CFG_NUM_S0: k_n0 = longint'(signed'(cfg_data));
					CFG_DEN_S2: k_d2 = longint'(signed'(cfg_data));
					CFG_DEN_S1: k_d1 = longint'(signed'(cfg_data));
					CFG_DEN_S0: k_d0 = longint'(signed'(cfg_data));
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				filter_step(s_tdata[30:0], s_tdata[62:31], want);
				expected_q.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with no item pending", m_tdata, 32'd0);
				end else begin
					want = expected_q.pop_front();
					if (m_tdata !== want.sample_out)
						report_mismatch("sample_out", m_tdata, want.sample_out);
					if (m_tuser !== want.zero_denominator)
						report_mismatch("zero_denominator", {31'd0, m_tuser},
							{31'd0, want.zero_denominator});
				end
			end
			fail_count <= errors;
			outstanding <= expected_q.size();
		end
	end

endmodule

/* test/tb_second_order_tustin_filter_top.sv */
`timescale 1ns / 1ps

module tb_second_order_tustin_filter_top;
	import sotf_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int DRAIN_CYCLES = 200;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 65;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;

	localparam int MIX_SCALED = 0;
	localparam int MIX_FULL = 1;
	localparam int MIX_EDGE = 2;

	localparam logic [31:0] Q_ONE = 32'h0001_0000;
	localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] S_MIN = 32'h8000_0000;
	localparam logic [30:0] DT_MAX = 31'h7FFF_FFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = 64'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 3'd0;
	logic [31:0] cfg_data = 32'd0;

	int fail_count;
	int outstanding;
	int cycles = 0;
	bit steady_run = 1'b0;

	second_order_tustin_filter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	tustin_filter_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady_run || r < 55) return 0;
		if (r < 93) return $urandom_range(1, 4);
		return $urandom_range(15, 50);
	endfunction

	function automatic int stall_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 60);
	endfunction

	// output side: ready for a while, then maybe a stall
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(1, 30);
			m_tready <= 1'b1;
			repeat (n) @(posedge clk);
			n = stall_len();
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	// leaves s_tvalid high so back-to-back items need no toggle
	task automatic send_sample(input logic [30:0] dt, input logic [31:0] x);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, x, dt};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic load_coeffs(input logic [31:0] n2, input logic [31:0] n1,
			input logic [31:0] n0, input logic [31:0] d2, input logic [31:0] d1,
			input logic [31:0] d0);
		settle();
		put_reg($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B, $urandom);
		put_reg(CFG_NUM_S2, n2);
		put_reg(CFG_NUM_S1, n1);
		put_reg(CFG_NUM_S0, n0);
		put_reg(CFG_DEN_S2, d2);
		put_reg(CFG_DEN_S1, d1);
		put_reg(CFG_DEN_S0, d0);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_coef(input int mix);
		logic [31:0] v;
		int bits;
		case (mix)
			MIX_SCALED: begin
				bits = $urandom_range(2, 20);
				v = $urandom_range(0, (1 << bits) - 1);
				if ($urandom_range(0, 1)) v = -v;
				if ($urandom_range(0, 9) == 0) v = 32'd0;
			end
			MIX_FULL: v = $urandom;
			default: begin
				case ($urandom_range(0, 4))
					0: v = S_MAX;
					1: v = S_MIN;
					2: v = 32'd0;
					3: v = Q_ONE;
					default: v = -Q_ONE;
				endcase
			end
		endcase
		return v;
	endfunction

	function automatic logic [30:0] pick_step();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return 31'd0;
		if (r < 70) return 31'($urandom_range(1, 4096));
		if (r < 90) return 31'($urandom_range(1, 1 << 20));
		return 31'($urandom);
	endfunction

	function automatic logic [31:0] pick_sample();
		int r;
		logic [31:0] v;
		r = $urandom_range(0, 99);
		if (r < 55) return $urandom;
		if (r < 95) begin
			v = $urandom_range(0, 1 << 18);
			return $urandom_range(0, 1) ? -v : v;
		end
		return $urandom_range(0, 1) ? S_MAX : S_MIN;
	endfunction

	initial begin
		int mix;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients: hold, then zero denominator at small and full step
		send_sample(31'd0, 32'h1234_5678);
		send_sample(31'd655, S_MAX);
		send_sample(DT_MAX, S_MIN);

		// low-pass, dt about 10 ms
		load_coeffs(32'd0, 32'd0, Q_ONE, 32'd655, 32'd13107, Q_ONE);
		repeat (4) send_sample(31'd655, Q_ONE);
		send_sample(31'd655, S_MIN);
		send_sample(31'd655, S_MAX);
		send_sample(31'd0, 32'hDEAD_BEEF);
		send_sample(31'd655, 32'hFFFF_FFFF);
		send_sample(31'd1, 32'd0);
		send_sample(DT_MAX, S_MAX);
		send_sample(31'h7FFF, S_MIN);

		// T^2 truncates to zero at dt = 1: zero denominator with nonzero config
		load_coeffs(Q_ONE, Q_ONE, Q_ONE, 32'd0, 32'd0, Q_ONE);
		send_sample(31'd1, Q_ONE);
		send_sample(31'd256, S_MAX);
		send_sample(31'd256, S_MIN);

		load_coeffs(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX);
		send_sample(DT_MAX, S_MAX);
		send_sample(31'd1, S_MIN);
		send_sample(31'h10000, S_MAX);
		load_coeffs(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN);
		send_sample(DT_MAX, S_MIN);
		send_sample(31'd1, S_MAX);
		send_sample(31'h10000, S_MIN);

		for (int p = 0; p < PHASES; p++) begin
			mix = (p == 0) ? MIX_EDGE : p % 3;
			load_coeffs(pick_coef(mix), pick_coef(mix), pick_coef(mix),
				pick_coef(mix), pick_coef(mix), pick_coef(mix));
			steady_run = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 49) == 0) settle();
				send_sample(pick_step(), pick_sample());
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
